// File: hdl/csem_pkg.sv
// Shared constants, codes and types of the counting semaphore table.
package csem_pkg;

    // Table sizes
    localparam int NUM_SEMS    = 64;
    localparam int NUM_WAITERS = 64;

    localparam int SEM_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int NODE_W   = (NUM_WAITERS > 1) ? $clog2(NUM_WAITERS) : 1;
    localparam int SDEPTH_W = $clog2(NUM_SEMS + 1);
    localparam int WDEPTH_W = $clog2(NUM_WAITERS + 1);

    // Field widths
    localparam int TYPE_W = 3;
    localparam int VAL_W  = 16;
    localparam int ID_W   = 16;

    // Stream word layout
    localparam int IN_BITS    = SEM_W + VAL_W + ID_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ID_W + VAL_W;

    // Reply queue holds the two words of a wake-up pair
    localparam int Q_DEPTH = 2;

    // Request codes
    typedef logic [TYPE_W-1:0] req_code_t;
    localparam req_code_t REQ_ALLOC   = 3'd0;
    localparam req_code_t REQ_FREE    = 3'd1;
    localparam req_code_t REQ_WAIT    = 3'd2;
    localparam req_code_t REQ_TRYWAIT = 3'd3;
    localparam req_code_t REQ_POST    = 3'd4;
    localparam req_code_t REQ_GET     = 3'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
        logic wake;
    } ctrl_cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic needs_wake;
        logic room;
    } ctrl_sts_t;

    // One reply word
    typedef struct packed {
        logic [ID_W-1:0]  reply_to;
        logic [VAL_W-1:0] reply_value;
        logic             failed;
        logic             last;
    } result_t;

    // Replies handed to the output queue at once
    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    // Waiter node contents
    typedef struct packed {
        logic [ID_W-1:0]   who;
        logic [NODE_W-1:0] next;
        logic              next_valid;
    } node_t;

endpackage

// File: hdl/csem_ctrl.sv
// Request sequencer: accepts a word, runs the table update, waits for queue room.
module csem_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  csem_pkg::ctrl_sts_t sts,
    output csem_pkg::ctrl_cmd_t cmd
);
    import csem_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAKE} state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.needs_wake) begin
                    state_next = ST_WAKE;
                end else if (sts.room) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAKE: begin
                if (sts.room) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        s_axis_tready = (state_reg == ST_IDLE);
        cmd.load      = (state_reg == ST_IDLE) && s_axis_tvalid;
        cmd.exec      = (state_reg == ST_EXEC) && !sts.needs_wake && sts.room;
        cmd.fetch     = (state_reg == ST_EXEC) && sts.needs_wake;
        cmd.wake      = (state_reg == ST_WAKE) && sts.room;
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/csem_dp.sv
// Semaphore tables, free stacks, waiter pool and the per-request update logic.
module csem_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  csem_pkg::ctrl_cmd_t                 cmd,
    input  logic [csem_pkg::TYPE_W-1:0]         in_type,
    input  logic [csem_pkg::SEM_W-1:0]          in_idx,
    input  logic [csem_pkg::VAL_W-1:0]          in_init,
    input  logic [csem_pkg::ID_W-1:0]           in_who,
    output logic                                needs_wake,
    output csem_pkg::push_t                     push
);
    import csem_pkg::*;

    // Captured request
    req_code_t         type_reg;
    logic [SEM_W-1:0]  idx_reg;
    logic [VAL_W-1:0]  init_reg;
    logic [ID_W-1:0]   who_reg;

    // Control state
    logic [SDEPTH_W-1:0]    fs_depth_reg;
    logic [WDEPTH_W-1:0]    fw_depth_reg;
    logic [NUM_SEMS-1:0]    alloc_reg;
    logic [NUM_SEMS-1:0]    head_vld_reg;
    logic [NUM_SEMS-1:0]    cnt_vld_reg;
    logic [NUM_SEMS-1:0]    fstk_vld_reg;
    logic [NUM_WAITERS-1:0] wstk_vld_reg;

    // Memories
    logic [VAL_W-1:0]  cnt_mem  [NUM_SEMS];
    logic [NODE_W-1:0] head_mem [NUM_SEMS];
    logic [SEM_W-1:0]  fstk_mem [NUM_SEMS];
    logic [NODE_W-1:0] wstk_mem [NUM_WAITERS];
    node_t             node_mem [NUM_WAITERS];

    // Registered read data
    logic [VAL_W-1:0]  cnt_rd_reg;
    logic [NODE_W-1:0] head_rd_reg;
    logic [SEM_W-1:0]  fstk_rd_reg;
    logic [NODE_W-1:0] wstk_rd_reg;
    node_t             node_rd_reg;

    // Write ports
    logic              cnt_we;
    logic [SEM_W-1:0]  cnt_wa;
    logic [VAL_W-1:0]  cnt_wd;
    logic              head_we;
    logic [NODE_W-1:0] head_wd;
    logic              fstk_we;
    logic              wstk_we;
    logic [NODE_W-1:0] wstk_wd;
    logic              node_we;
    logic              alloc_we;
    logic [SEM_W-1:0]  alloc_wa;
    logic              alloc_wd;
    logic              hv_we;
    logic [SEM_W-1:0]  hv_wa;
    logic              hv_wd;
    logic              fs_inc;
    logic              fs_dec;
    logic              fw_inc;
    logic              fw_dec;

    // Derived values
    logic [SEM_W-1:0]  fs_top;
    logic [SEM_W-1:0]  fs_slot;
    logic [NODE_W-1:0] fw_top;
    logic [NODE_W-1:0] fw_slot;
    logic [VAL_W-1:0]  cnt_cur;
    logic [SEM_W-1:0]  fstk_cur;
    logic [NODE_W-1:0] wstk_cur;
    logic              idx_ok;
    logic              type_ok;

    assign fs_top   = SEM_W'(fs_depth_reg - 1'b1);
    assign fs_slot  = SEM_W'(fs_depth_reg);
    assign fw_top   = NODE_W'(fw_depth_reg - 1'b1);
    assign fw_slot  = NODE_W'(fw_depth_reg);
    assign cnt_cur  = cnt_vld_reg[idx_reg] ? cnt_rd_reg : '0;
    assign fstk_cur = fstk_vld_reg[fs_top] ? fstk_rd_reg
                                           : SEM_W'(NUM_SEMS - 1) - fs_top;
    assign wstk_cur = wstk_vld_reg[fw_top] ? wstk_rd_reg
                                           : NODE_W'(NUM_WAITERS - 1) - fw_top;
    assign idx_ok   = (32'(idx_reg) < NUM_SEMS);
    assign type_ok  = (type_reg <= REQ_GET);

    assign needs_wake = (type_reg == REQ_POST) && idx_ok && head_vld_reg[idx_reg];

    // Decide the table updates and the replies
    always_comb begin
        cnt_we   = 1'b0;
        cnt_wa   = idx_reg;
        cnt_wd   = '0;
        head_we  = 1'b0;
        head_wd  = wstk_cur;
        fstk_we  = 1'b0;
        wstk_we  = 1'b0;
        wstk_wd  = head_rd_reg;
        node_we  = 1'b0;
        alloc_we = 1'b0;
        alloc_wa = idx_reg;
        alloc_wd = 1'b0;
        hv_we    = 1'b0;
        hv_wa    = idx_reg;
        hv_wd    = 1'b0;
        fs_inc   = 1'b0;
        fs_dec   = 1'b0;
        fw_inc   = 1'b0;
        fw_dec   = 1'b0;

        push.n                  = 2'd0;
        push.first.reply_to     = who_reg;
        push.first.reply_value  = '0;
        push.first.failed       = 1'b1;
        push.first.last         = 1'b1;
        push.second.reply_to    = who_reg;
        push.second.reply_value = '0;
        push.second.failed      = 1'b0;
        push.second.last        = 1'b1;

        if (cmd.exec) begin
            push.n = 2'd1;
            priority if (type_reg == REQ_ALLOC) begin
                // Pop a free entry and set it up
                if (fs_depth_reg != '0) begin
                    fs_dec                 = 1'b1;
                    cnt_we                 = 1'b1;
                    cnt_wa                 = fstk_cur;
                    cnt_wd                 = init_reg;
                    alloc_we               = 1'b1;
                    alloc_wa               = fstk_cur;
                    alloc_wd               = 1'b1;
                    hv_we                  = 1'b1;
                    hv_wa                  = fstk_cur;
                    hv_wd                  = 1'b0;
                    push.first.reply_value = VAL_W'(fstk_cur);
                    push.first.failed      = 1'b0;
                end
            end else if (!type_ok || !idx_ok) begin
                push.first.failed = 1'b1;
            end else begin
                unique case (type_reg)
                    REQ_FREE: begin
                        // Push the entry back when it is idle
                        if (alloc_reg[idx_reg] && !head_vld_reg[idx_reg] &&
                            fs_depth_reg < SDEPTH_W'(NUM_SEMS)) begin
                            alloc_we          = 1'b1;
                            alloc_wd          = 1'b0;
                            fstk_we           = 1'b1;
                            fs_inc            = 1'b1;
                            push.first.failed = 1'b0;
                        end
                    end
                    REQ_WAIT, REQ_TRYWAIT: begin
                        if (cnt_cur != '0) begin
                            cnt_we            = 1'b1;
                            cnt_wd            = cnt_cur - 1'b1;
                            push.first.failed = 1'b0;
                        end else if (type_reg == REQ_WAIT && fw_depth_reg != '0) begin
                            // Block: link a pool node in front of the list
                            fw_dec  = 1'b1;
                            node_we = 1'b1;
                            head_we = 1'b1;
                            head_wd = wstk_cur;
                            hv_we   = 1'b1;
                            hv_wd   = 1'b1;
                            push.n  = 2'd0;
                        end
                    end
                    REQ_POST: begin
                        cnt_we            = 1'b1;
                        cnt_wd            = cnt_cur + 1'b1;
                        push.first.failed = 1'b0;
                    end
                    REQ_GET: begin
                        push.first.reply_value = cnt_cur;
                        push.first.failed      = 1'b0;
                    end
                    default: push.first.failed = 1'b1;
                endcase
            end
        end else if (cmd.wake) begin
            // Unlink the newest waiter and return its node
            head_we = 1'b1;
            head_wd = node_rd_reg.next;
            hv_we   = 1'b1;
            hv_wd   = node_rd_reg.next_valid;
            if (fw_depth_reg < WDEPTH_W'(NUM_WAITERS)) begin
                wstk_we = 1'b1;
                fw_inc  = 1'b1;
            end
            push.n                 = 2'd2;
            push.first.reply_to    = node_rd_reg.who;
            push.first.reply_value = '0;
            push.first.failed      = 1'b0;
            push.first.last        = 1'b0;
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            type_reg <= in_type;
            idx_reg  <= in_idx;
            init_reg <= in_init;
            who_reg  <= in_who;
        end
    end

    // Memory reads and writes
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cnt_rd_reg  <= cnt_mem[in_idx];
            head_rd_reg <= head_mem[in_idx];
            fstk_rd_reg <= fstk_mem[fs_top];
            wstk_rd_reg <= wstk_mem[fw_top];
        end
        if (cmd.fetch) begin
            node_rd_reg <= node_mem[head_rd_reg];
        end
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (head_we) begin
            head_mem[idx_reg] <= head_wd;
        end
        if (fstk_we) begin
            fstk_mem[fs_slot] <= idx_reg;
        end
        if (wstk_we) begin
            wstk_mem[fw_slot] <= wstk_wd;
        end
        if (node_we) begin
            node_mem[wstk_cur] <= '{who: who_reg, next: head_rd_reg,
                                    next_valid: head_vld_reg[idx_reg]};
        end
    end

    // Valid bits, flags and stack depths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_depth_reg <= SDEPTH_W'(NUM_SEMS);
            fw_depth_reg <= WDEPTH_W'(NUM_WAITERS);
            alloc_reg    <= '0;
            head_vld_reg <= '0;
            cnt_vld_reg  <= '0;
            fstk_vld_reg <= '0;
            wstk_vld_reg <= '0;
        end else begin
            if (fs_inc) begin
                fs_depth_reg <= fs_depth_reg + 1'b1;
            end else if (fs_dec) begin
                fs_depth_reg <= fs_depth_reg - 1'b1;
            end
            if (fw_inc) begin
                fw_depth_reg <= fw_depth_reg + 1'b1;
            end else if (fw_dec) begin
                fw_depth_reg <= fw_depth_reg - 1'b1;
            end
            if (alloc_we) begin
                alloc_reg[alloc_wa] <= alloc_wd;
            end
            if (hv_we) begin
                head_vld_reg[hv_wa] <= hv_wd;
            end
            if (cnt_we) begin
                cnt_vld_reg[cnt_wa] <= 1'b1;
            end
            if (fstk_we) begin
                fstk_vld_reg[fs_slot] <= 1'b1;
            end
            if (wstk_we) begin
                wstk_vld_reg[fw_slot] <= 1'b1;
            end
        end
    end

endmodule

// File: hdl/csem_outq.sv
// Two-word reply queue between the table update and the output stream.
module csem_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  csem_pkg::push_t   push,
    output logic              room,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output csem_pkg::result_t head_word
);
    import csem_pkg::*;

    result_t    q_reg [Q_DEPTH];
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr0;
    logic       wr1;
    logic       pop;

    assign wr0           = rd_ptr_reg ^ cnt_reg[0];
    assign wr1           = ~wr0;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign room          = (cnt_reg == 2'd0);
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign head_word     = q_reg[rd_ptr_reg];

    // Store pushed words
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            q_reg[wr0] <= push.first;
        end
        if (push.n == 2'd2) begin
            q_reg[wr1] <= push.second;
        end
    end

    // Advance pointer and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + push.n - {1'b0, pop};
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// File: hdl/counting_semaphore_table.sv
// Top level of the counting semaphore table: controller, datapath and reply queue.
//
// One request word is taken at a time. The idle state accepts it and reads
// the count, waiter-head and free-stack tables (registered read ports); the
// execute state decides and writes back. A post that wakes a waiter also
// passes through the wake state, because the waiter node is read from the
// pool only once the head of the list is known. Replies go into a two-word
// queue, so a new request is taken while earlier replies wait on the output;
// the write-back holds until that queue has drained. A blocked wait gives no
// reply; a post with waiters gives the wake-up word (tlast low) followed by
// the poster's reply. Reset needs no clearing pass: every table that has a
// reset value carries a valid bit per entry.
module counting_semaphore_table (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sem_index, init_value, requester_id, zero padding
    input  logic [csem_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic [csem_pkg::TYPE_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // reply_to, reply_value
    output logic [csem_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // failed
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import csem_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    push_t     push;
    result_t   head_word;
    logic      needs_wake;
    logic      room;

    assign sts.needs_wake = needs_wake;
    assign sts.room       = room;

    csem_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    csem_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_type    (s_axis_tuser),
        .in_idx     (s_axis_tdata[SEM_W-1:0]),
        .in_init    (s_axis_tdata[SEM_W +: VAL_W]),
        .in_who     (s_axis_tdata[SEM_W+VAL_W +: ID_W]),
        .needs_wake (needs_wake),
        .push       (push)
    );

    csem_outq u_outq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .head_word     (head_word)
    );

    // Pack the reply word
    assign m_axis_tdata = {head_word.reply_value, head_word.reply_to};
    assign m_axis_tuser = head_word.failed;
    assign m_axis_tlast = head_word.last;

endmodule

// File: hdl/csem_check.sv
// Port-level checks for the counting semaphore table, bound to the top level.
module csem_check (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [csem_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input logic [csem_pkg::TYPE_W-1:0]        s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [csem_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                               m_axis_tuser,
    input logic                               m_axis_tlast
);
    import csem_pkg::*;

    // A wake-up word never fails and carries a zero value
    a_wake_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser &&
            m_axis_tdata[OUT_DATA_W-1:ID_W] == '0)
        else $error("wake-up word with failure or nonzero value");

    // The poster's reply is already queued behind a wake-up word
    a_wake_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("wake-up word not followed by the poster reply");

    // A failed reply carries a zero value
    a_fail_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[OUT_DATA_W-1:ID_W] == '0)
        else $error("failed reply with nonzero value");

    // One request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted on two consecutive cycles");

    // A stalled reply word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
            $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled reply word changed");

endmodule

bind counting_semaphore_table csem_check u_csem_check (.*);
